// ----- design/mtfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mtfr_pkg - multi-type frame receiver package
// Frame constants, frame kinds, configuration and result types.
// ----------------------------------------------------------------------------
package mtfr_pkg;

  localparam logic [7:0] HdrVel    = 8'hAA;
  localparam logic [7:0] HdrScene  = 8'hBB;
  localparam logic [7:0] HdrRoute  = 8'hDD;
  localparam logic [7:0] SyncByte  = 8'h55;

  localparam logic [4:0] LenVel    = 5'd12;
  localparam logic [4:0] LenScene  = 5'd4;
  localparam logic [4:0] LenRoute  = 5'd23;
  localparam int unsigned BufBytes = 23;

  // configuration register indexes
  localparam logic [7:0] RegSceneFirst  = 8'd0;
  localparam logic [7:0] RegSceneSecond = 8'd1;
  localparam logic [7:0] RegRouteLo     = 8'd2;
  localparam logic [7:0] RegRouteHi     = 8'd3;

  typedef enum logic [1:0] {
    KIND_VEL   = 2'd0,
    KIND_SCENE = 2'd1,
    KIND_ROUTE = 2'd2
  } kind_e;

  typedef logic [BufBytes-1:0][7:0] frame_buf_t;

  typedef struct packed {
    logic [7:0] scene_first;
    logic [7:0] scene_second;
    logic [7:0] route_lo;
    logic [7:0] route_hi;
  } cfg_t;

  typedef struct packed {
    logic [31:0] vel;
    logic [31:0] scene;
    logic [31:0] route;
  } counts_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [7:0]  code;
    logic [7:0]  route_index;
    logic [7:0]  route_points;
    logic        loop_flag;
    logic [63:0] first_value;
    logic [63:0] second_value;
    logic [31:0] kind_count;
  } result_t;

  function automatic logic [4:0] frame_len(kind_e kind);
    logic [4:0] len;
    unique case (kind)
      KIND_VEL:   len = LenVel;
      KIND_SCENE: len = LenScene;
      KIND_ROUTE: len = LenRoute;
      default:    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- design/mtfr_decode.sv -----
// ----------------------------------------------------------------------------
// mtfr_decode - frame field decode
// Builds the result fields from the frame buffer and checks scene/route codes.
// ----------------------------------------------------------------------------
module mtfr_decode import mtfr_pkg::*; (
  input  kind_e      kind_i,
  input  frame_buf_t buf_i,
  input  cfg_t       cfg_i,
  input  counts_t    counts_i,
  output logic       code_ok_o,
  output result_t    res_o
);

  logic [7:0] code;

  assign code = buf_i[2];

  always_comb begin
    res_o      = '0;
    code_ok_o  = 1'b0;
    res_o.code = code;
    unique case (kind_i)
      KIND_VEL: begin
        code_ok_o          = 1'b1;
        res_o.frame_kind   = KIND_VEL;
        res_o.first_value  = {32'd0, buf_i[6], buf_i[5], buf_i[4], buf_i[3]};
        res_o.second_value = {32'd0, buf_i[10], buf_i[9], buf_i[8], buf_i[7]};
        res_o.kind_count   = counts_i.vel + 32'd1;
      end
      KIND_SCENE: begin
        code_ok_o        = (code == cfg_i.scene_first) || (code == cfg_i.scene_second);
        res_o.frame_kind = KIND_SCENE;
        res_o.kind_count = counts_i.scene + 32'd1;
      end
      KIND_ROUTE: begin
        code_ok_o          = (code >= cfg_i.route_lo) && (code <= cfg_i.route_hi);
        res_o.frame_kind   = KIND_ROUTE;
        res_o.route_index  = buf_i[3];
        res_o.route_points = buf_i[4];
        res_o.loop_flag    = (buf_i[5] != 8'd0);
        res_o.first_value  = {buf_i[13], buf_i[12], buf_i[11], buf_i[10],
                              buf_i[9], buf_i[8], buf_i[7], buf_i[6]};
        res_o.second_value = {buf_i[21], buf_i[20], buf_i[19], buf_i[18],
                              buf_i[17], buf_i[16], buf_i[15], buf_i[14]};
        res_o.kind_count   = counts_i.route + 32'd1;
      end
      default: begin
        code_ok_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/multi_type_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// multi_type_frame_receiver_unit - header-synced fixed-length frame parser
// Assembles velocity, scene and route frames from a byte stream, checks the
// XOR checksum and code ranges, and emits one beat per good frame.
// ----------------------------------------------------------------------------
//  channel | signals                              | dir | beat
//  --------+--------------------------------------+-----+------------------------
//  in      | in_valid_i, in_stall_o, rx_byte_i    | in  | one received byte
//  out     | out_valid_o, out_stall_i, fields     | out | one decoded good frame
//  cfg     | cfg_valid_i, cfg_ready_o, idx, data  | in  | one register write
//
//  One byte per cycle while in_stall_o is low. A byte is handled in the cycle
//  it is taken; the output register loads a frame's result as its last byte
//  is taken. in_stall_o rises only while a result is held and out_stall_i is
//  high. Reset (async, active low) closes any open frame, clears the per-kind
//  counts and loads the register defaults. cfg_ready_o is always 1.
// ----------------------------------------------------------------------------
module multi_type_frame_receiver_unit import mtfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // frame output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  frame_kind_o,
  output logic [7:0]  code_o,
  output logic [7:0]  route_index_o,
  output logic [7:0]  route_points_o,
  output logic        loop_flag_o,
  output logic [63:0] first_value_o,
  output logic [63:0] second_value_o,
  output logic [31:0] kind_count_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // frame tracking; pos_q == 0 means no frame open
  logic [4:0] pos_q, pos_d;
  kind_e      kind_q, kind_d;
  logic [7:0] xor_q, xor_d;
  frame_buf_t buf_q;
  counts_t    counts_q;
  cfg_t       cfg_q;

  logic       out_valid_q;
  result_t    res_q;
  result_t    res_dec;
  logic       code_ok;

  logic       accept;
  logic       buf_we;
  logic       fire;
  logic [4:0] len;
  logic       open_ok;
  logic       is_hdr;
  kind_e      hdr_kind;

  assign cfg_ready_o = 1'b1;
  // output register drains or is empty -> a new byte may enter
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  assign len = frame_len(kind_q);
  // an open frame whose position has run past its length is dropped
  assign open_ok = (pos_q != 5'd0) && (pos_q < len) && (pos_q < LenRoute);

  always_comb begin
    is_hdr   = 1'b1;
    hdr_kind = KIND_VEL;
    priority if (rx_byte_i == HdrVel) begin
      hdr_kind = KIND_VEL;
    end else if (rx_byte_i == HdrScene) begin
      hdr_kind = KIND_SCENE;
    end else if (rx_byte_i == HdrRoute) begin
      hdr_kind = KIND_ROUTE;
    end else begin
      is_hdr = 1'b0;
    end
  end

  mtfr_decode u_decode (
    .kind_i    (kind_q),
    .buf_i     (buf_q),
    .cfg_i     (cfg_q),
    .counts_i  (counts_q),
    .code_ok_o (code_ok),
    .res_o     (res_dec)
  );

  // per-byte step
  always_comb begin
    pos_d  = pos_q;
    kind_d = kind_q;
    xor_d  = xor_q;
    buf_we = 1'b0;
    fire   = 1'b0;
    if (!open_ok || (pos_q == 5'd1 && rx_byte_i != SyncByte)) begin
      // idle, or sync missed: this byte may start a new frame
      xor_d = 8'd0;
      if (is_hdr) begin
        pos_d  = 5'd1;
        kind_d = hdr_kind;
      end else begin
        pos_d = 5'd0;
      end
    end else begin
      buf_we = 1'b1;
      if (({1'b0, pos_q} + 6'd1) < {1'b0, len}) begin
        if (pos_q >= 5'd2) begin
          xor_d = xor_q ^ rx_byte_i;
        end
        pos_d = pos_q + 5'd1;
      end else begin
        // last byte: checksum against running XOR
        fire  = (xor_q == rx_byte_i) && code_ok;
        pos_d = 5'd0;
        xor_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 5'd0;
      kind_q      <= KIND_VEL;
      xor_q       <= 8'd0;
      counts_q    <= '0;
      out_valid_q <= 1'b0;
      cfg_q.scene_first  <= 8'd1;
      cfg_q.scene_second <= 8'd2;
      cfg_q.route_lo     <= 8'd1;
      cfg_q.route_hi     <= 8'd5;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegSceneFirst:  cfg_q.scene_first  <= cfg_data_i;
          RegSceneSecond: cfg_q.scene_second <= cfg_data_i;
          RegRouteLo:     cfg_q.route_lo     <= cfg_data_i;
          RegRouteHi:     cfg_q.route_hi     <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        pos_q  <= pos_d;
        kind_q <= kind_d;
        xor_q  <= xor_d;
      end
      if (accept && fire) begin
        out_valid_q <= 1'b1;
        unique case (kind_q)
          KIND_VEL:   counts_q.vel   <= res_dec.kind_count;
          KIND_SCENE: counts_q.scene <= res_dec.kind_count;
          KIND_ROUTE: counts_q.route <= res_dec.kind_count;
          default: ;
        endcase
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // frame buffer and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && buf_we) begin
      buf_q[pos_q] <= rx_byte_i;
    end
    if (accept && fire) begin
      res_q <= res_dec;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_kind_o   = res_q.frame_kind;
  assign code_o         = res_q.code;
  assign route_index_o  = res_q.route_index;
  assign route_points_o = res_q.route_points;
  assign loop_flag_o    = res_q.loop_flag;
  assign first_value_o  = res_q.first_value;
  assign second_value_o = res_q.second_value;
  assign kind_count_o   = res_q.kind_count;

endmodule
